FILE: src/tmsr_pkg.sv
// shared constants, state and opcode types for the trimmed-mean spike rejector
package tmsr_pkg;

  localparam int BLOCK_LEN_DEF    = 5;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int SIGMA_W          = 23;
  localparam int SIGMA_RESET      = 256;
  localparam int SPIKE_FACTOR     = 3;

  // block sequencer states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_MIN,
    ST_MAX,
    ST_SUM,
    ST_THR0,
    ST_THR1,
    ST_MUL,
    ST_SUB,
    ST_CMP,
    ST_OUT
  } st_t;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_LT,
    OP_GT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MAG_GT
  } alu_op_t;

  // control bundle into the shared unit
  typedef struct packed {
    alu_op_t op;
  } alu_ctl_t;

endpackage

FILE: src/tmsr_alu.sv
// shared add, subtract, compare and small multiply unit
module tmsr_alu #(
  parameter int W  = 30,
  parameter int CW = 3
) (
  input  tmsr_pkg::alu_ctl_t ctl,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic [CW-1:0]       m,
  output logic signed [W-1:0] res,
  output logic                flag
);
  import tmsr_pkg::*;

  logic signed [W+CW:0] prod;
  logic signed [W:0]    mag;
  logic signed [W:0]    b_ext;

  // multiply by a small unsigned count, magnitude for the threshold test
  always_comb begin
    prod  = a * $signed({1'b0, m});
    mag   = a[W-1] ? -{a[W-1], a} : {a[W-1], a};
    b_ext = {b[W-1], b};
  end

  // operation select
  always_comb begin
    res  = a;
    flag = 1'b0;
    case (ctl.op)
      OP_LT:     flag = (a < b);
      OP_GT:     flag = (a > b);
      OP_ADD:    res  = a + b;
      OP_SUB:    res  = a - b;
      OP_MUL:    res  = prod[W-1:0];
      OP_MAG_GT: flag = (mag > b_ext);
      default: begin
        res  = a;
        flag = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/block_trimmed_mean_spike_rejector_top.sv
// top level: block buffer, sequencer and replay of the trimmed-mean spike rejector
// takes one sample beat per cycle until BLOCK_LEN samples are stored, then is busy
// with a min pass, a max pass, a sum pass, the threshold and then a multiply, subtract
// and compare for each test in the shared unit, then replays BLOCK_LEN result beats,
// one per cycle at best; a new block is taken only once its last beat is issued.
// synchronous active-low reset clears control, valid flags and sets sigma to 256
module block_trimmed_mean_spike_rejector_top #(
  parameter int BLOCK_LEN    = tmsr_pkg::BLOCK_LEN_DEF,
  parameter int SAMPLE_WIDTH = tmsr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmsr_pkg::SIGMA_W-1:0]   cfg_sigma,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_sample_valid,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  output logic                           out_keep,
  output logic                           out_spike,
  output logic                           out_last
);
  import tmsr_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int IW   = $clog2(BLOCK_LEN);
  localparam int CW0  = $clog2(BLOCK_LEN + 1);
  localparam int CW   = (CW0 < 2) ? 2 : CW0;
  localparam int BASE = (SW > SIGMA_W + 2) ? SW : SIGMA_W + 2;
  localparam int W    = BASE + CW + 2;
  localparam logic [IW-1:0] LAST_IDX = IW'(BLOCK_LEN - 1);

  // block store and flags
  logic signed [SW-1:0] mem_r [BLOCK_LEN];
  logic [BLOCK_LEN-1:0] vld_r;
  logic [BLOCK_LEN-1:0] spike_r, spike_nxt;

  st_t                  state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [SIGMA_W-1:0]   sigma_r;
  logic                 have_r, have_nxt;
  logic signed [SW-1:0] best_r, best_nxt;
  logic [IW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [W-1:0]  sum_r, sum_nxt, thr_r, thr_nxt, tmp_r, tmp_nxt;
  logic [CW-1:0]        n_r, n_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_sample_r, out_sample_nxt;
  logic                 out_keep_r, out_keep_nxt;
  logic                 out_spike_r, out_spike_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_beat;
  logic signed [SW-1:0] cur;
  logic                 cur_vld;
  logic signed [W-1:0]  cur_ext, best_ext, sigma_ext;

  alu_ctl_t             alu_ctl;
  logic signed [W-1:0]  alu_a, alu_b, alu_res;
  logic [CW-1:0]        alu_m;
  logic                 alu_flag;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_FILL);
  assign in_beat   = in_valid && in_ready;

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_keep   = out_keep_r;
  assign out_spike  = out_spike_r;
  assign out_last   = out_last_r;

  // current entry under the sequencer
  assign cur       = mem_r[idx_r];
  assign cur_vld   = vld_r[idx_r];
  assign cur_ext   = {{(W - SW){cur[SW-1]}}, cur};
  assign best_ext  = {{(W - SW){best_r[SW-1]}}, best_r};
  assign sigma_ext = {{(W - SIGMA_W){1'b0}}, sigma_r};

  tmsr_alu #(
    .W  (W),
    .CW (CW)
  ) u_alu (
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .m    (alu_m),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // shared unit operand select
  always_comb begin
    alu_ctl.op = OP_ADD;
    alu_a      = cur_ext;
    alu_b      = best_ext;
    alu_m      = n_r;
    case (state_r)
      ST_MIN:  alu_ctl.op = OP_LT;
      ST_MAX:  alu_ctl.op = OP_GT;
      ST_SUM: begin
        alu_ctl.op = OP_ADD;
        alu_a      = sum_r;
        alu_b      = cur_ext;
      end
      ST_THR0: begin
        alu_ctl.op = OP_MUL;
        alu_a      = sigma_ext;
        alu_m      = CW'(SPIKE_FACTOR);
      end
      ST_THR1: begin
        alu_ctl.op = OP_MUL;
        alu_a      = thr_r;
      end
      ST_MUL:  alu_ctl.op = OP_MUL;
      ST_SUB: begin
        alu_ctl.op = OP_SUB;
        alu_a      = tmp_r;
        alu_b      = sum_r;
      end
      ST_CMP: begin
        alu_ctl.op = OP_MAG_GT;
        alu_a      = tmp_r;
        alu_b      = thr_r;
      end
      default: alu_ctl.op = OP_ADD;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: if (in_beat && idx_r == LAST_IDX) state_nxt = ST_MIN;
      ST_MIN:  if (idx_r == LAST_IDX) state_nxt = ST_MAX;
      ST_MAX:  if (idx_r == LAST_IDX) state_nxt = ST_SUM;
      ST_SUM:  if (idx_r == LAST_IDX) state_nxt = ST_THR0;
      ST_THR0: state_nxt = ST_THR1;
      ST_THR1: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (idx_r == LAST_IDX) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if ((!out_valid_r || out_ready) && idx_r == LAST_IDX) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // datapath and output updates
  always_comb begin
    idx_nxt        = idx_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    sum_nxt        = sum_r;
    n_nxt          = n_r;
    thr_nxt        = thr_r;
    tmp_nxt        = tmp_r;
    spike_nxt      = spike_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_keep_nxt   = out_keep_r;
    out_spike_nxt  = out_spike_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      // gather samples
      ST_FILL: begin
        if (in_beat) begin
          if (idx_r == LAST_IDX) begin
            idx_nxt  = '0;
            have_nxt = 1'b0;
            sum_nxt  = '0;
            n_nxt    = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      // earliest minimum, then earliest maximum
      ST_MIN, ST_MAX: begin
        if (cur_vld && (!have_r || alu_flag)) begin
          have_nxt = 1'b1;
          best_nxt = cur;
          if (state_r == ST_MIN) lo_nxt = idx_r;
          else                   hi_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt  = '0;
          have_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // sum of the trimmed set
      ST_SUM: begin
        if (cur_vld && idx_r != lo_r && idx_r != hi_r) begin
          sum_nxt = alu_res;
          n_nxt   = n_r + 1'b1;
        end
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      // threshold = 3 * sigma * n
      ST_THR0, ST_THR1: thr_nxt = alu_res;
      // |n*x - sum| > thr, three steps per entry
      ST_MUL, ST_SUB: tmp_nxt = alu_res;
      ST_CMP: begin
        spike_nxt[idx_r] = cur_vld && alu_flag;
        idx_nxt          = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      // replay the block
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = cur_vld ? cur : '0;
          out_keep_nxt   = cur_vld && !spike_r[idx_r];
          out_spike_nxt  = spike_r[idx_r];
          out_last_nxt   = (idx_r == LAST_IDX);
          idx_nxt        = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        end
      end
      default: idx_nxt = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      idx_r       <= '0;
      have_r      <= 1'b0;
      n_r         <= '0;
      vld_r       <= '0;
      spike_r     <= '0;
      out_valid_r <= 1'b0;
      sigma_r     <= SIGMA_W'(SIGMA_RESET);
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
      n_r         <= n_nxt;
      spike_r     <= spike_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_beat) vld_r[idx_r] <= in_sample_valid;
      if (cfg_valid && cfg_ready) sigma_r <= cfg_sigma;
    end
  end

  // payload registers and sample store
  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    sum_r        <= sum_nxt;
    thr_r        <= thr_nxt;
    tmp_r        <= tmp_nxt;
    out_sample_r <= out_sample_nxt;
    out_keep_r   <= out_keep_nxt;
    out_spike_r  <= out_spike_nxt;
    out_last_r   <= out_last_nxt;
    if (in_beat) mem_r[idx_r] <= in_sample;
  end

`ifndef SYNTHESIS
  // a result beat is never both kept and a spike
  a_keep_spike_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_keep && out_spike))
    else $error("keep and spike both set");

  // an invalid entry replays as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_keep && !out_spike) |-> (out_sample == '0))
    else $error("invalid entry replayed nonzero");

  // the trimmed set always holds fewer than BLOCK_LEN samples
  a_trim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_THR0) |-> (n_r < CW'(BLOCK_LEN)))
    else $error("trimmed count too large");

  // the final sample of a block starts the min pass
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && idx_r == LAST_IDX) |=> (state_r == ST_MIN && idx_r == '0))
    else $error("block not started after final sample");
`endif

endmodule

FILE: tb/tmsr_replay_checker.sv
// checker that predicts each block's replay beats and compares them with the result channel
module tmsr_replay_checker #(
  parameter int BLK = tmsr_pkg::BLOCK_LEN_DEF,
  parameter int SW  = tmsr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tmsr_pkg::SIGMA_W-1:0] cfg_sigma,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [SW-1:0]        in_sample,
  input  logic                        in_sample_valid,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [SW-1:0]        out_sample,
  input  logic                        out_keep,
  input  logic                        out_spike,
  input  logic                        out_last,
  output int                          mismatches,
  output int                          awaited
);

  localparam int SGW = tmsr_pkg::SIGMA_W;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 keep;
    logic                 spike;
    logic                 last;
  } replay_beat_t;

  // predictor copy of the block buffer and the sigma register
  logic signed [SW-1:0] held_smp [BLK];
  logic                 held_vld [BLK];
  int                   fill;
  logic [SGW-1:0]       sigma_now;
  replay_beat_t         replay_q [$];
  int                   beat_no;

  // trimmed mean without the first min and first max, exact three-sigma test, then replay
  function automatic void flag_block_spikes();
    int           lo;
    int           hi;
    longint       sum;
    longint       n;
    longint       thr;
    longint       d;
    logic         spk;
    replay_beat_t b;
    lo  = -1;
    hi  = -1;
    sum = 0;
    n   = 0;
    for (int i = 0; i < BLK; i++) begin
      if (held_vld[i]) begin
        if (lo < 0 || held_smp[i] < held_smp[lo]) lo = i;
        if (hi < 0 || held_smp[i] > held_smp[hi]) hi = i;
      end
    end
    for (int i = 0; i < BLK; i++) begin
      if (held_vld[i] && i != lo && i != hi) begin
        sum += longint'(held_smp[i]);
        n++;
      end
    end
    thr = longint'(sigma_now) * tmsr_pkg::SPIKE_FACTOR * n;
    for (int i = 0; i < BLK; i++) begin
      spk = 1'b0;
      if (held_vld[i] && n != 0) begin
        d = longint'(held_smp[i]) * n - sum;
        if (d < 0) d = -d;
        spk = (d > thr);
      end
      b.smp   = held_vld[i] ? held_smp[i] : '0;
      b.keep  = held_vld[i] && !spk;
      b.spike = spk;
      b.last  = (i == BLK - 1);
      replay_q.push_back(b);
    end
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    replay_beat_t want;
    if (!rst_n) begin
      fill       = 0;
      sigma_now  = SGW'(tmsr_pkg::SIGMA_RESET);
      mismatches = 0;
      beat_no    = 0;
      for (int i = 0; i < BLK; i++) held_vld[i] = 1'b0;
      replay_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) sigma_now = cfg_sigma;
      // gather the sample beat; a full block yields its replay
      if (in_valid && in_ready) begin
        held_smp[fill] = in_sample;
        held_vld[fill] = in_sample_valid;
        fill++;
        if (fill == BLK) begin
          fill = 0;
          flag_block_spikes();
        end
      end
      // compare the result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (replay_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %0d: sample %0d keep %0b spike %0b last %0b",
                     beat_no, out_sample, out_keep, out_spike, out_last);
        end else begin
          want = replay_q.pop_front();
          if (out_sample !== want.smp || out_keep !== want.keep ||
              out_spike !== want.spike || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result beat %0d: expected sample %0d keep %0b spike %0b last %0b,",
                        " got sample %0d keep %0b spike %0b last %0b"},
                       beat_no, $signed(want.smp), want.keep, want.spike, want.last,
                       out_sample, out_keep, out_spike, out_last);
          end
        end
        beat_no++;
      end
    end
    awaited = replay_q.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top: sample and sigma stimulus, receiver stalls and the verdict
module tb;

  localparam int BLK     = tmsr_pkg::BLOCK_LEN_DEF;
  localparam int SW      = tmsr_pkg::SAMPLE_WIDTH_DEF;
  localparam int SGW     = tmsr_pkg::SIGMA_W;
  localparam longint SMP_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_MIN = -(longint'(1) << (SW - 1));

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;
  typedef enum int {BK_NOISE, BK_EXTREME, BK_SPARSE, BK_CLUSTER} blk_kind_t;

  // directed blocks: extremes, all invalid, split ties, all equal, two valid, exact threshold
  localparam int DIR_SMP [30] = '{
    -8388608, 8388607, 0, -1, 1,
    123, -5, 8388607, -8388608, 77,
    10, -3, 10, -3, 10,
    5, 5, 5, 5, 5,
    1000000, 42, -1000000, 7, 7,
    -1, 0, 1152, 0, 1153
  };
  localparam int DIR_VLD [30] = '{
    1, 1, 1, 1, 1,
    0, 0, 0, 0, 0,
    1, 1, 1, 1, 1,
    1, 1, 1, 1, 1,
    1, 0, 1, 0, 0,
    1, 1, 1, 1, 1
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [SGW-1:0]       cfg_sigma = '0;
  logic                 in_valid = 1'b0;
  logic signed [SW-1:0] in_sample = '0;
  logic                 in_sample_valid = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [SW-1:0] out_sample;
  logic                 out_keep;
  logic                 out_spike;
  logic                 out_last;
  int                   mismatches;
  int                   awaited;
  int                   burst_left = 0;
  int                   rx_tick = 0;
  rx_mode_t             rx_mode = RX_OPEN;
  logic [SGW-1:0]       sigma_plan [6];

  block_trimmed_mean_spike_rejector_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sigma       (cfg_sigma),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_sample_valid (in_sample_valid),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_keep        (out_keep),
    .out_spike       (out_spike),
    .out_last        (out_last)
  );

  tmsr_replay_checker #(.BLK(BLK), .SW(SW)) replay_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sigma       (cfg_sigma),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_sample_valid (in_sample_valid),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_keep        (out_keep),
    .out_spike       (out_spike),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .awaited         (awaited)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver stalls, switching its pattern now and then
  always @(posedge clk) begin
    if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_tick = rx_tick + 1;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
      default:   out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one sample beat, then a burst gap when the burst runs out
  task automatic put_sample(input logic signed [SW-1:0] s, input logic v);
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_sample_valid <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  endtask

  // hold the sender until every predicted beat is out, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_sigma(input logic [SGW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_sigma <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one block of five: mostly a cluster around a base with spikes near three sigma
  task automatic send_random_block(input longint sig);
    blk_kind_t kind;
    int        pick;
    longint    base;
    longint    spread;
    longint    off;
    longint    v;
    logic      vld;
    pick = $urandom_range(0, 9);
    if (pick == 0) kind = BK_NOISE;
    else if (pick == 1) kind = BK_EXTREME;
    else if (pick == 2) kind = BK_SPARSE;
    else kind = BK_CLUSTER;
    base   = longint'($urandom_range(0, 8388607)) - 4194304;
    spread = (sig > 1048576) ? 2097152 : 2 * sig + 1;
    for (int i = 0; i < BLK; i++) begin
      case (kind)
        BK_NOISE: begin
          v   = longint'($urandom_range(0, 16777215)) + SMP_MIN;
          vld = 1'($urandom_range(0, 1));
        end
        BK_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       v = SMP_MIN;
            1:       v = SMP_MAX;
            2:       v = 0;
            default: v = -1;
          endcase
          vld = 1'b1;
        end
        BK_SPARSE: begin
          v   = base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
          vld = ($urandom_range(0, 2) == 0);
        end
        default: begin
          v = base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
          // spike candidate, sometimes right at the threshold
          if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 0) off = 3 * sig + longint'($urandom_range(0, 2)) - 1;
            else off = 3 * sig + longint'($urandom_range(0, 32'(2 * sig + 2)));
            v = ($urandom_range(0, 1) == 0) ? base + off : base - off;
          end
          vld = ($urandom_range(0, 9) != 0);
        end
      endcase
      if (v > SMP_MAX) v = SMP_MAX;
      if (v < SMP_MIN) v = SMP_MIN;
      put_sample(SW'(v), vld);
    end
  endtask

  // stimulus and verdict
  initial begin
    sigma_plan = '{SGW'(0), SGW'(8388607), SGW'(1), SGW'(100),
                   SGW'($urandom_range(2, 5000)), SGW'(256)};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 30; i++) put_sample(SW'(DIR_SMP[i]), DIR_VLD[i] != 0);
    for (int p = 0; p < 6; p++) begin
      settle();
      write_sigma(sigma_plan[p]);
      for (int b = 0; b < 10; b++) send_random_block(longint'(sigma_plan[p]));
    end
    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("block_trimmed_mean_spike_rejector_top: match");
    end else begin
      $display("block_trimmed_mean_spike_rejector_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("block_trimmed_mean_spike_rejector_top: mismatch");
    $finish;
  end

endmodule
